[src/vn3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vn3_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned IN_TDATA_W  = NUM_AXES * COORD_W;

  // input reg, coord mults, hash (3), x/y/z blends (2 each)
  localparam int unsigned NUM_STAGES  = 11;

  // per-axis lattice mix multipliers: x, y, z
  localparam logic [COORD_W-1:0] MIX_C [NUM_AXES] = '{
    32'h8da6_b343,
    32'hd816_3841,
    32'hcb1a_b31f
  };

  localparam logic [COORD_W-1:0] AVAL_MUL = 32'h7feb_352d;
  localparam int unsigned        SHIFT_A  = 13;
  localparam int unsigned        SHIFT_B  = 15;

endpackage

`default_nettype wire

[src/vn3_hash.sv]
`timescale 1ns / 1ps
`default_nettype none

// Corner hash tail: xor of premultiplied coords, avalanche, top bits out.
module vn3_hash import vn3_pkg::*; #(
  parameter int unsigned OUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [COORD_W-1:0]  px_i,
  input  logic [COORD_W-1:0]  py_i,
  input  logic [COORD_W-1:0]  pz_i,
  output logic [OUT_BITS-1:0] corner_o
);

  logic [COORD_W-1:0]  mix_d, mix_q;
  logic [COORD_W-1:0]  aval_d, aval_q;
  logic [COORD_W-1:0]  fold;
  logic [OUT_BITS-1:0] corner_q;

  always_comb begin
    mix_d  = px_i ^ py_i ^ pz_i;
    mix_d  = mix_d ^ (mix_d >> SHIFT_A);
    aval_d = mix_q * AVAL_MUL;
    fold   = aval_q ^ (aval_q >> SHIFT_B);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q    <= mix_d;
      aval_q   <= aval_d;
      corner_q <= fold[COORD_W-1 -: OUT_BITS];
    end
  end

  assign corner_o = corner_q;

endmodule

`default_nettype wire

[src/vn3_lerp.sv]
`timescale 1ns / 1ps
`default_nettype none

// Two-stage lerp: |b-a|*w registered, then a +/- (product >> W_BITS).
module vn3_lerp #(
  parameter int unsigned VAL_BITS = 16,
  parameter int unsigned W_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [VAL_BITS-1:0] a_i,
  input  logic [VAL_BITS-1:0] b_i,
  input  logic [W_BITS-1:0]   w_i,
  output logic [VAL_BITS-1:0] r_o
);

  localparam int unsigned PROD_W = VAL_BITS + W_BITS;

  logic                up;
  logic [VAL_BITS-1:0] diff;
  logic [PROD_W-1:0]   prod_d, prod_q;
  logic [VAL_BITS-1:0] base_q;
  logic                up_q;
  logic [VAL_BITS-1:0] step;
  logic [VAL_BITS-1:0] r_d, r_q;

  always_comb begin
    up     = (b_i >= a_i);
    diff   = up ? (b_i - a_i) : (a_i - b_i);
    prod_d = PROD_W'(diff) * PROD_W'(w_i);
    step   = prod_q[PROD_W-1:W_BITS];
    r_d    = up_q ? (base_q + step) : (base_q - step);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      base_q <= a_i;
      up_q   <= up;
      r_q    <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

[src/value_noise_3d_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width                 tdata (low bit up)
// s_axis    in   96                    pos_x[31:0], pos_y[31:0], pos_z[31:0]
// m_axis    out  OUT_BITS to bytes     noise_value[OUT_BITS-1:0], zero pad
//
// One point per cycle while m_axis does not stall; 11 register stages (split,
// coord mults, 3 hash stages, 3 two-stage blends). Reset clears only the
// stage valid bits.
// The whole pipe advances on one enable: it moves when the output register
// is empty or being taken, so a stall on m_axis freezes every stage and
// drops s_axis_tready in the same cycle. Nothing is lost or repeated.
module value_noise_3d_unit import vn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned OUT_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata,  // pos_x, pos_y, pos_z
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [((OUT_BITS+7)/8)*8-1:0]      m_axis_tdata   // noise_value, zero pad
);

  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned FSQ_W       = 2 * FRAC_BITS;
  localparam int unsigned T_W         = FRAC_BITS + 2;
  localparam int unsigned WP_W        = FSQ_W + 2;
  localparam logic [T_W-1:0] THREE_ONE = T_W'(3) << FRAC_BITS;

  // advance enable shared by all stages
  logic adv;
  logic [NUM_STAGES-1:0] valid_q;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 1: floor cell, cell + 1 (wraps), fraction
  logic signed [COORD_W-1:0] pos_a    [NUM_AXES];
  logic [COORD_W-1:0]        cell_d   [NUM_AXES];
  logic [COORD_W-1:0]        cell_lo_q[NUM_AXES];
  logic [COORD_W-1:0]        cell_hi_q[NUM_AXES];
  logic [FRAC_BITS-1:0]      frac_q   [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      pos_a[a]  = $signed(s_axis_tdata[a*COORD_W +: COORD_W]);
      cell_d[a] = COORD_W'(pos_a[a] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        cell_lo_q[a] <= cell_d[a];
        cell_hi_q[a] <= cell_d[a] + COORD_W'(1);
        frac_q[a]    <= pos_a[a][FRAC_BITS-1:0];
      end
    end
  end

  // ---- stage 2: per-axis mix products, f^2 and (3 - 2f) for the fade
  logic [COORD_W-1:0]   prod_lo_q[NUM_AXES];
  logic [COORD_W-1:0]   prod_hi_q[NUM_AXES];
  logic [FSQ_W-1:0]     fsq      [NUM_AXES];
  logic [FRAC_BITS-1:0] f2_q     [NUM_AXES];
  logic [T_W-1:0]       t_q      [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      fsq[a] = FSQ_W'(frac_q[a]) * FSQ_W'(frac_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_lo_q[a] <= cell_lo_q[a] * MIX_C[a];
        prod_hi_q[a] <= cell_hi_q[a] * MIX_C[a];
        f2_q[a]      <= fsq[a][FSQ_W-1:FRAC_BITS];
        t_q[a]       <= THREE_ONE - {1'b0, frac_q[a], 1'b0};
      end
    end
  end

  // ---- stages 3..5: smoothstep weight, then carried alongside the hash
  logic [WP_W-1:0]      wp  [NUM_AXES];
  logic [FRAC_BITS-1:0] w3_q[NUM_AXES];
  logic [FRAC_BITS-1:0] w4_q[NUM_AXES];
  logic [FRAC_BITS-1:0] w5_q[NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      wp[a] = WP_W'(f2_q[a]) * WP_W'(t_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        w3_q[a] <= wp[a][FSQ_W-1:FRAC_BITS];
        w4_q[a] <= w3_q[a];
        w5_q[a] <= w4_q[a];
      end
    end
  end

  // corner index: bit 0 picks x+1, bit 1 picks y+1, bit 2 picks z+1
  logic [OUT_BITS-1:0] corner[NUM_CORNERS];

  for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_corner
    vn3_hash #(
      .OUT_BITS (OUT_BITS)
    ) u_hash (
      .clk_i    (clk_i),
      .en_i     (adv),
      .px_i     (((c & 1) != 0) ? prod_hi_q[0] : prod_lo_q[0]),
      .py_i     (((c & 2) != 0) ? prod_hi_q[1] : prod_lo_q[1]),
      .pz_i     (((c & 4) != 0) ? prod_hi_q[2] : prod_lo_q[2]),
      .corner_o (corner[c])
    );
  end

  // ---- stages 6..11: blend along x, then y, then z
  logic [FRAC_BITS-1:0] wy6_q, wy7_q;
  logic [FRAC_BITS-1:0] wz6_q, wz7_q, wz8_q, wz9_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wy6_q <= w5_q[1];
      wy7_q <= wy6_q;
      wz6_q <= w5_q[2];
      wz7_q <= wz6_q;
      wz8_q <= wz7_q;
      wz9_q <= wz8_q;
    end
  end

  logic [OUT_BITS-1:0] mx[4];
  logic [OUT_BITS-1:0] my[2];
  logic [OUT_BITS-1:0] noise;

  for (genvar j = 0; j < 4; j++) begin : g_lerp_x
    vn3_lerp #(
      .VAL_BITS (OUT_BITS),
      .W_BITS   (FRAC_BITS)
    ) u_lerp (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (corner[2*j]),
      .b_i   (corner[2*j+1]),
      .w_i   (w5_q[0]),
      .r_o   (mx[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_lerp_y
    vn3_lerp #(
      .VAL_BITS (OUT_BITS),
      .W_BITS   (FRAC_BITS)
    ) u_lerp (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mx[2*j]),
      .b_i   (mx[2*j+1]),
      .w_i   (wy7_q),
      .r_o   (my[j])
    );
  end

  vn3_lerp #(
    .VAL_BITS (OUT_BITS),
    .W_BITS   (FRAC_BITS)
  ) u_lerp_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (my[0]),
    .b_i   (my[1]),
    .w_i   (wz9_q),
    .r_o   (noise)
  );

  assign m_axis_tdata = OUT_TDATA_W'(noise);

endmodule

`default_nettype wire

[src/vn3_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module vn3_checker #(
  parameter int unsigned DATA_W = 16
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              s_axis_tready,
  input wire              m_axis_tvalid,
  input wire              m_axis_tready,
  input wire [DATA_W-1:0] m_axis_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked while output empty");

  // a stalled full output freezes the pipe
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

  // a new result only appears after the pipe advanced
  a_rise_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tready))
    else $error("result appeared without pipe advance");

endmodule

bind value_noise_3d_unit vn3_checker #(
  .DATA_W (OUT_TDATA_W)
) u_vn3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/sv/value_noise_3d_unit_test.sv]
`timescale 1ns / 1ps

module value_noise_3d_unit_test;
  import vn3_pkg::*;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned OUT_BITS      = 16;
  localparam int unsigned OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned RANDOM_POINTS = 1530;
  localparam int unsigned QUIET_TAIL    = 250;   // last points: no idling on either side
  localparam int unsigned NUM_SPECIAL   = 10;

  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [OUT_BITS-1:0] noise_t;
  // packed: x lands in the low bits of tdata
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  // Expected noise values, oldest first, computed when a point transfer is seen.
  class noise_checker;
    noise_t      noise_due[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function logic [31:0] lattice_hash(coord_t cx, coord_t cy, coord_t cz);
      logic [31:0] h;
      h = (cx * MIX_C[0]) ^ (cy * MIX_C[1]) ^ (cz * MIX_C[2]);
      h = h ^ (h >> SHIFT_A);
      h = h * AVAL_MUL;
      h = h ^ (h >> SHIFT_B);
      return h;
    endfunction

    // smoothstep on a Q0.FRAC fraction, both products truncated
    function logic [63:0] smooth_weight(logic [63:0] f);
      logic [63:0] f2;
      logic [63:0] slope;
      f2    = (f * f) >> FRAC_BITS;
      slope = (64'd3 << FRAC_BITS) - (f << 1);
      return (f2 * slope) >> FRAC_BITS;
    endfunction

    // lerp with the step truncated toward zero
    function logic [63:0] lerp_q(logic [63:0] a, logic [63:0] b, logic [63:0] w);
      if (b >= a) begin
        return a + (((b - a) * w) >> FRAC_BITS);
      end
      return a - (((a - b) * w) >> FRAC_BITS);
    endfunction

    function noise_t lattice_noise(point_t p);
      coord_t      pos  [3];
      coord_t      base [3];
      coord_t      nxt  [3];
      logic [63:0] wgt  [3];
      logic [63:0] cv   [8];
      coord_t      ix, iy, iz;
      logic [63:0] m00, m10, m01, m11, m0, m1, r;
      pos[0] = p.x;
      pos[1] = p.y;
      pos[2] = p.z;
      for (int a = 0; a < 3; a++) begin
        base[a] = coord_t'($signed(pos[a]) >>> FRAC_BITS);  // floor
        nxt[a]  = base[a] + 1'b1;                           // wraps at the top cell
        wgt[a]  = smooth_weight(64'(pos[a][FRAC_BITS-1:0]));
      end
      // corner index: bit 0 = x+1, bit 1 = y+1, bit 2 = z+1
      for (int k = 0; k < 8; k++) begin
        ix    = ((k & 1) != 0) ? nxt[0] : base[0];
        iy    = ((k & 2) != 0) ? nxt[1] : base[1];
        iz    = ((k & 4) != 0) ? nxt[2] : base[2];
        cv[k] = 64'(lattice_hash(ix, iy, iz) >> (32 - OUT_BITS));
      end
      m00 = lerp_q(cv[0], cv[1], wgt[0]);
      m10 = lerp_q(cv[2], cv[3], wgt[0]);
      m01 = lerp_q(cv[4], cv[5], wgt[0]);
      m11 = lerp_q(cv[6], cv[7], wgt[0]);
      m0  = lerp_q(m00, m10, wgt[1]);
      m1  = lerp_q(m01, m11, wgt[1]);
      r   = lerp_q(m0, m1, wgt[2]);
      return noise_t'(r);
    endfunction

    function void note_point(point_t p);
      noise_due.push_back(lattice_noise(p));
    endfunction

    function void check_noise(logic [OUT_TDATA_W-1:0] got);
      logic [OUT_TDATA_W-1:0] want;
      if (noise_due.size() == 0) begin
        errors++;
        $display("%0t: noise transfer with none expected, expected none actual %h",
                 $time, got);
        return;
      end
      want = OUT_TDATA_W'(noise_due.pop_front());
      if (got !== want) begin
        errors++;
        $display("%0t: noise_value mismatch, expected %h actual %h", $time, want, got);
      end
    endfunction

    function int pending();
      return noise_due.size();
    endfunction
  endclass

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // pos_x, pos_y, pos_z
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // noise_value

  // 1-in-N chance of an idle burst per transfer or cycle; 0 means none
  int unsigned  idle_odds = 3;
  noise_checker ledger    = new();

  value_noise_3d_unit #(
    .FRAC_BITS(FRAC_BITS),
    .OUT_BITS (OUT_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic point_t make_point(coord_t x, coord_t y, coord_t z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Mix of full-range values, points near the origin, points around the
  // wrap of the top cell, and fractions at their edges.
  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(0, 4))
      0: c = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      1: c = 32'h7ffe_0000 + $urandom_range(0, 32'h0003_ffff);
      2: begin
        c = $urandom();
        case ($urandom_range(0, 4))
          0: c[FRAC_BITS-1:0] = '0;
          1: c[FRAC_BITS-1:0] = '1;
          2: c[FRAC_BITS-1:0] = FRAC_BITS'(1);
          3: c[FRAC_BITS-1:0] = FRAC_BITS'(1) << (FRAC_BITS - 1);
          default: c[FRAC_BITS-1:0] = ~FRAC_BITS'(1);
        endcase
      end
      default: c = $urandom();
    endcase
    return c;
  endfunction

  task automatic drive_point(point_t p);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_point(p);
  endtask

  // result side: check every transfer, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        ledger.check_noise(m_axis_tdata);
      end
      if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(1, 15);
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    coord_t special [NUM_SPECIAL];
    special = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                32'h0000_ffff, 32'h0000_8000, 32'h7fff_0000, 32'hffff_0000,
                32'h0001_0000, 32'h8000_8000};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, top-cell wrap, negative floors, fraction edges
    for (int i = 0; i < NUM_SPECIAL; i++) begin
      drive_point(make_point(special[i], special[i], special[i]));
      drive_point(make_point(special[i], special[(i + 3) % NUM_SPECIAL],
                             special[(i + 7) % NUM_SPECIAL]));
    end

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i >= RANDOM_POINTS - QUIET_TAIL) begin
        idle_odds = 0;
      end else begin
        case ((i / 150) % 3)
          0: idle_odds = 0;
          1: idle_odds = 6;
          default: idle_odds = 2;
        endcase
      end
      drive_point(make_point(rand_coord(), rand_coord(), rand_coord()));
    end
    s_axis_tvalid <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (NUM_STAGES + 8) @(posedge clk_i);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

[value_noise_3d_unit.f]
src/vn3_pkg.sv
src/vn3_hash.sv
src/vn3_lerp.sv
src/value_noise_3d_unit.sv
src/vn3_checker.sv
tb/sv/value_noise_3d_unit_test.sv
